// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the complex arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define ASSERT_AFTER(label, clk, rst, ante, n, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
      else $error(msg);

`endif

// File: rtl/cau_pkg.sv
// Types and constants shared by the complex arithmetic unit.
package cau_pkg;

   localparam int PART_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_WIDTH = 2 * PART_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;
   localparam int QUO_BITS   = PART_WIDTH;
   localparam int FRONT_STAGES = 5;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_SAT      = 2'd1,
      STATUS_DIV_ZERO = 2'd2
   } status_type;

   typedef logic signed [PART_WIDTH-1:0] part_type;

   typedef struct packed {
      opcode_type opcode;
      part_type   a_re;
      part_type   a_im;
      part_type   b_re;
      part_type   b_im;
   } req_type;

   typedef struct packed {
      part_type   res_re;
      part_type   res_im;
      status_type status;
   } rsp_type;

   // One quotient of the divider: partial remainder, dividend bits still to
   // be shifted in, quotient bits so far, overflow flag and result sign.
   typedef struct packed {
      logic [PROD_WIDTH-1:0] rem;
      logic [PART_WIDTH-1:0] lo;
      logic [PART_WIDTH-1:0] quo;
      logic                  big;
      logic                  neg;
   } lane_type;

   // Everything one item carries down the divider chain.
   typedef struct packed {
      logic                  valid;
      logic                  is_div;
      logic                  div_zero;
      logic [PART_WIDTH-1:0] res_re;
      logic [PART_WIDTH-1:0] res_im;
      status_type            status;
      logic [PROD_WIDTH-1:0] den;
      lane_type              re;
      lane_type              im;
   } cell_type;

endpackage

// File: rtl/complex_arith_unit.sv
// Top level of the complex arithmetic unit: add, subtract, multiply, divide.
//
//   channel   ports                          direction  transfer when
//   request   start, busy, req_payload       in         start high and busy low
//   response  rsp_strobe, rsp_payload        out        rsp_strobe high
//
// Fully pipelined: a new item may be started every cycle.
// Each result passes through five operand stages, one divider cell per
// quotient bit (32 cells), and an output register.
// Synchronous reset empties the pipeline; busy is high during reset and in the
// first cycle after it, and low from then on.
// The response cannot be held off, so nothing in the pipeline ever stalls.
`include "assert_macros.svh"

module complex_arith_unit import cau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   localparam int LATENCY = FRONT_STAGES + QUO_BITS + 1;

   typedef struct packed {
      logic                  sat;
      logic [PART_WIDTH-1:0] val;
   } part_res_type;

   function automatic part_res_type finish_lane(input lane_type l);
      logic [PART_WIDTH-1:0] lim;
      logic [PART_WIDTH-1:0] mag;
      part_res_type r;
      lim   = l.neg ? {1'b1, {(PART_WIDTH-1){1'b0}}} : {1'b0, {(PART_WIDTH-1){1'b1}}};
      r.sat = l.big || (l.quo > lim);
      mag   = r.sat ? lim : l.quo;
      r.val = l.neg ? (~mag + 1'b1) : mag;
      return r;
   endfunction

   logic     busy_ff, busy_in;
   logic     req_accept;
   cell_type link [QUO_BITS+1];
   logic     rsp_strobe_ff, rsp_strobe_in;
   rsp_type  rsp_payload_ff, rsp_payload_in;
   part_res_type fin_re, fin_im;
   cell_type last;

   assign busy_in    = 1'b0;
   assign req_accept = start && !busy_ff;

   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_accept),
      .in_payload (req_payload),
      .head       (link[0])
   );

   for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
      cau_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .prev_stage (link[i]),
         .next_stage (link[i+1])
      );
   end

   assign last = link[QUO_BITS];

   always_comb begin
      fin_re        = finish_lane(last.re);
      fin_im        = finish_lane(last.im);
      rsp_strobe_in = last.valid;
      if (!last.is_div) begin
         rsp_payload_in.res_re = last.res_re;
         rsp_payload_in.res_im = last.res_im;
         rsp_payload_in.status = last.status;
      end else if (last.div_zero) begin
         rsp_payload_in.res_re = '0;
         rsp_payload_in.res_im = '0;
         rsp_payload_in.status = STATUS_DIV_ZERO;
      end else begin
         rsp_payload_in.res_re = fin_re.val;
         rsp_payload_in.res_im = fin_im.val;
         rsp_payload_in.status = (fin_re.sat || fin_im.sat) ? STATUS_SAT : STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign busy        = busy_ff;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_payload_ff;

   `ASSERT_AFTER(a_result_follows, clock, reset, req_accept, LATENCY, rsp_strobe, "accepted item gave no result")
   `ASSERT_IMPLIES(a_result_has_source, clock, reset, rsp_strobe, $past(req_accept, LATENCY), "result without an accepted item")
   `ASSERT_IMPLIES(a_div_zero_clear, clock, reset, rsp_strobe && rsp_payload.status == STATUS_DIV_ZERO, rsp_payload.res_re == '0 && rsp_payload.res_im == '0, "divide by zero result not cleared")

endmodule

// File: rtl/cau_front.sv
// Operand pipeline: sums, products, saturation and divider set-up.
module cau_front import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_payload,
   output cell_type head
);

   localparam int ADD_WIDTH = PART_WIDTH + 1;
   localparam int DVD_WIDTH = PROD_WIDTH + FRAC_BITS;
   localparam int CMP_WIDTH = PROD_WIDTH + PART_WIDTH;

   typedef struct packed {
      logic                  sat;
      logic [PART_WIDTH-1:0] val;
   } sat_type;

   function automatic sat_type sat_part(input logic signed [SUM_WIDTH-1:0] v);
      logic signed [SUM_WIDTH-1:0] hi;
      logic signed [SUM_WIDTH-1:0] lo;
      sat_type r;
      hi = SUM_WIDTH'({1'b0, {(PART_WIDTH-1){1'b1}}});
      lo = ~hi;
      r.sat = 1'b0;
      r.val = v[PART_WIDTH-1:0];
      if (v > hi) begin
         r.sat = 1'b1;
         r.val = hi[PART_WIDTH-1:0];
      end else if (v < lo) begin
         r.sat = 1'b1;
         r.val = lo[PART_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic lane_type init_lane(input logic [PROD_WIDTH-1:0] mag, input logic neg,
                                          input logic [PROD_WIDTH-1:0] den);
      logic [CMP_WIDTH-1:0] n_ext;
      logic [CMP_WIDTH-1:0] d_ext;
      logic [DVD_WIDTH-1:0] dvd;
      lane_type r;
      n_ext = CMP_WIDTH'(mag) << FRAC_BITS;
      d_ext = CMP_WIDTH'(den) << PART_WIDTH;
      dvd   = DVD_WIDTH'(mag) << FRAC_BITS;
      // A quotient of 2^PART_WIDTH or more cannot fit the chain and saturates.
      r.big = (n_ext >= d_ext);
      r.neg = neg;
      r.rem = PROD_WIDTH'(dvd >> PART_WIDTH);
      r.lo  = dvd[PART_WIDTH-1:0];
      r.quo = '0;
      return r;
   endfunction

   logic [FRONT_STAGES-1:0] vld_ff, vld_in;

   // Stage 1
   opcode_type op1_ff, op1_in;
   part_type   a_re1_ff, a_im1_ff, b_re1_ff, b_im1_ff;
   logic signed [ADD_WIDTH-1:0] add_re1_ff, add_re1_in, add_im1_ff, add_im1_in;

   // Stage 2
   opcode_type op2_ff;
   logic signed [ADD_WIDTH-1:0] add_re2_ff, add_im2_ff;
   logic signed [PROD_WIDTH-1:0] p_rr2_ff, p_rr2_in, p_ii2_ff, p_ii2_in;
   logic signed [PROD_WIDTH-1:0] p_ri2_ff, p_ri2_in, p_ir2_ff, p_ir2_in;
   logic signed [PROD_WIDTH-1:0] p_bb_re2_ff, p_bb_re2_in, p_bb_im2_ff, p_bb_im2_in;

   // Stage 3
   opcode_type op3_ff;
   logic signed [ADD_WIDTH-1:0] add_re3_ff, add_im3_ff;
   logic signed [SUM_WIDTH-1:0] sum_re3_ff, sum_re3_in, sum_im3_ff, sum_im3_in;
   logic [PROD_WIDTH-1:0] den3_ff, den3_in;

   // Stage 4
   logic is_div4_ff, is_div4_in, div_zero4_ff, div_zero4_in;
   logic [PART_WIDTH-1:0] res_re4_ff, res_re4_in, res_im4_ff, res_im4_in;
   status_type status4_ff, status4_in;
   logic [PROD_WIDTH-1:0] mag_re4_ff, mag_re4_in, mag_im4_ff, mag_im4_in;
   logic neg_re4_ff, neg_re4_in, neg_im4_ff, neg_im4_in;
   logic [PROD_WIDTH-1:0] den4_ff;

   // Stage 5
   cell_type head_ff, head_in;

   logic signed [SUM_WIDTH-1:0] shift_re, shift_im, flip_re, flip_im;
   sat_type sat_re, sat_im;

   assign vld_in = {vld_ff[FRONT_STAGES-2:0], in_valid};

   always_comb begin
      op1_in = in_payload.opcode;
      if (in_payload.opcode == OP_SUB) begin
         add_re1_in = ADD_WIDTH'(in_payload.a_re) - ADD_WIDTH'(in_payload.b_re);
         add_im1_in = ADD_WIDTH'(in_payload.a_im) - ADD_WIDTH'(in_payload.b_im);
      end else begin
         add_re1_in = ADD_WIDTH'(in_payload.a_re) + ADD_WIDTH'(in_payload.b_re);
         add_im1_in = ADD_WIDTH'(in_payload.a_im) + ADD_WIDTH'(in_payload.b_im);
      end
   end

   always_comb begin
      p_rr2_in    = a_re1_ff * b_re1_ff;
      p_ii2_in    = a_im1_ff * b_im1_ff;
      p_ri2_in    = a_re1_ff * b_im1_ff;
      p_ir2_in    = a_im1_ff * b_re1_ff;
      p_bb_re2_in = b_re1_ff * b_re1_ff;
      p_bb_im2_in = b_im1_ff * b_im1_ff;
   end

   always_comb begin
      case (op2_ff)
         OP_DIV: begin
            sum_re3_in = SUM_WIDTH'(p_rr2_ff) + SUM_WIDTH'(p_ii2_ff);
            sum_im3_in = SUM_WIDTH'(p_ir2_ff) - SUM_WIDTH'(p_ri2_ff);
         end
         default: begin
            sum_re3_in = SUM_WIDTH'(p_rr2_ff) - SUM_WIDTH'(p_ii2_ff);
            sum_im3_in = SUM_WIDTH'(p_ri2_ff) + SUM_WIDTH'(p_ir2_ff);
         end
      endcase
      // Both squares are non-negative, so their sum fits unsigned.
      den3_in = PROD_WIDTH'($unsigned(p_bb_re2_ff)) + PROD_WIDTH'($unsigned(p_bb_im2_ff));
   end

   always_comb begin
      // Arithmetic shift floors towards minus infinity.
      shift_re = sum_re3_ff >>> FRAC_BITS;
      shift_im = sum_im3_ff >>> FRAC_BITS;
      flip_re  = -sum_re3_ff;
      flip_im  = -sum_im3_ff;
      if (op3_ff == OP_MUL) begin
         sat_re = sat_part(shift_re);
         sat_im = sat_part(shift_im);
      end else begin
         sat_re = sat_part(SUM_WIDTH'(add_re3_ff));
         sat_im = sat_part(SUM_WIDTH'(add_im3_ff));
      end
      is_div4_in   = (op3_ff == OP_DIV);
      div_zero4_in = (den3_ff == '0);
      res_re4_in   = sat_re.val;
      res_im4_in   = sat_im.val;
      status4_in   = (sat_re.sat || sat_im.sat) ? STATUS_SAT : STATUS_OK;
      neg_re4_in   = sum_re3_ff[SUM_WIDTH-1];
      neg_im4_in   = sum_im3_ff[SUM_WIDTH-1];
      mag_re4_in   = neg_re4_in ? flip_re[PROD_WIDTH-1:0] : sum_re3_ff[PROD_WIDTH-1:0];
      mag_im4_in   = neg_im4_in ? flip_im[PROD_WIDTH-1:0] : sum_im3_ff[PROD_WIDTH-1:0];
   end

   always_comb begin
      head_in          = head_ff;
      head_in.valid    = vld_ff[FRONT_STAGES-2];
      head_in.is_div   = is_div4_ff;
      head_in.div_zero = div_zero4_ff;
      head_in.res_re   = res_re4_ff;
      head_in.res_im   = res_im4_ff;
      head_in.status   = status4_ff;
      head_in.den      = den4_ff;
      head_in.re       = init_lane(mag_re4_ff, neg_re4_ff, den4_ff);
      head_in.im       = init_lane(mag_im4_ff, neg_im4_ff, den4_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff      <= op1_in;
      a_re1_ff    <= in_payload.a_re;
      a_im1_ff    <= in_payload.a_im;
      b_re1_ff    <= in_payload.b_re;
      b_im1_ff    <= in_payload.b_im;
      add_re1_ff  <= add_re1_in;
      add_im1_ff  <= add_im1_in;

      op2_ff      <= op1_ff;
      add_re2_ff  <= add_re1_ff;
      add_im2_ff  <= add_im1_ff;
      p_rr2_ff    <= p_rr2_in;
      p_ii2_ff    <= p_ii2_in;
      p_ri2_ff    <= p_ri2_in;
      p_ir2_ff    <= p_ir2_in;
      p_bb_re2_ff <= p_bb_re2_in;
      p_bb_im2_ff <= p_bb_im2_in;

      op3_ff      <= op2_ff;
      add_re3_ff  <= add_re2_ff;
      add_im3_ff  <= add_im2_ff;
      sum_re3_ff  <= sum_re3_in;
      sum_im3_ff  <= sum_im3_in;
      den3_ff     <= den3_in;

      is_div4_ff   <= is_div4_in;
      div_zero4_ff <= div_zero4_in;
      res_re4_ff   <= res_re4_in;
      res_im4_ff   <= res_im4_in;
      status4_ff   <= status4_in;
      mag_re4_ff   <= mag_re4_in;
      mag_im4_ff   <= mag_im4_in;
      neg_re4_ff   <= neg_re4_in;
      neg_im4_ff   <= neg_im4_in;
      den4_ff      <= den3_ff;

      head_ff      <= head_in;
   end

   always_comb begin
      head       = head_ff;
      head.valid = vld_ff[FRONT_STAGES-1];
   end

endmodule

// File: rtl/cau_div_cell.sv
// One divider cell: produces one quotient bit for both result parts.
module cau_div_cell import cau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cell_type prev_stage,
   output cell_type next_stage
);

   function automatic lane_type div_step(input lane_type l, input logic [PROD_WIDTH-1:0] den);
      logic [PROD_WIDTH:0] trial;
      logic [PROD_WIDTH:0] diff;
      logic                ge;
      lane_type            r;
      trial = {l.rem, l.lo[PART_WIDTH-1]};
      diff  = trial - {1'b0, den};
      ge    = (trial >= {1'b0, den});
      r     = l;
      r.rem = ge ? diff[PROD_WIDTH-1:0] : trial[PROD_WIDTH-1:0];
      r.lo  = l.lo << 1;
      r.quo = {l.quo[PART_WIDTH-2:0], ge};
      return r;
   endfunction

   logic     valid_ff, valid_in;
   cell_type stage_ff, stage_in;

   always_comb begin
      valid_in    = prev_stage.valid;
      stage_in    = prev_stage;
      stage_in.re = div_step(prev_stage.re, prev_stage.den);
      stage_in.im = div_step(prev_stage.im, prev_stage.den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   always_comb begin
      next_stage       = stage_ff;
      next_stage.valid = valid_ff;
   end

endmodule
